// File: hw/rtl/alle_pkg.sv
package alle_pkg;

  // Segments of one pixel: 24 bits, each a high and a low segment.
  localparam int SegsPerPixel = 48;
  // Position of the latch segment that follows the last pixel of a frame.
  localparam int LatchSeg     = SegsPerPixel;
  localparam int SegIdxW      = $clog2(SegsPerPixel + 1);
  localparam int QueueDepth   = 2;
  localparam int CfgIndexW    = 3;
  localparam int CfgDataW     = 16;

  localparam logic [7:0]  BrightnessReset    = 8'd255;
  localparam logic [7:0]  OneHighTicksReset  = 8'd80;
  localparam logic [7:0]  OneLowTicksReset   = 8'd40;
  localparam logic [7:0]  ZeroHighTicksReset = 8'd32;
  localparam logic [7:0]  ZeroLowTicksReset  = 8'd72;
  localparam logic [15:0] LatchLowTicksReset = 16'd8500;

  typedef enum logic [CfgIndexW-1:0] {
    REG_BRIGHTNESS      = 3'd0,
    REG_ONE_HIGH_TICKS  = 3'd1,
    REG_ONE_LOW_TICKS   = 3'd2,
    REG_ZERO_HIGH_TICKS = 3'd3,
    REG_ZERO_LOW_TICKS  = 3'd4,
    REG_LATCH_LOW_TICKS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       final_pixel;
  } pixel_t;

  typedef struct packed {
    logic        line_level;
    logic [15:0] segment_ticks;
    logic        run_end;
  } segment_t;

  // Scaled pixel in transmit order: green, red, blue, MSB first.
  typedef struct packed {
    logic [23:0] grb;
    logic        final_pixel;
  } scaled_t;

  typedef struct packed {
    logic [7:0]  one_high_ticks;
    logic [7:0]  one_low_ticks;
    logic [7:0]  zero_high_ticks;
    logic [7:0]  zero_low_ticks;
    logic [15:0] latch_low_ticks;
  } timing_cfg_t;

  // Exact floor(p / 255) for any product of two bytes.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // A zero length reads as one tick.
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// File: hw/rtl/alle_front.sv
module alle_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  alle_pkg::pixel_t pixel,
  input  logic [7:0]       brightness,
  output logic             push_valid,
  input  logic             push_ready,
  output alle_pkg::scaled_t push_data
);
  import alle_pkg::*;

  logic        prod_valid;
  logic [15:0] prod_red;
  logic [15:0] prod_green;
  logic [15:0] prod_blue;
  logic        prod_final;
  logic        take;

  assign pixel_ready = !prod_valid || push_ready;
  assign take        = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (take) begin
      prod_valid <= 1'b1;
    end else if (push_ready) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_red   <= 16'(pixel.red_level) * 16'(brightness);
      prod_green <= 16'(pixel.green_level) * 16'(brightness);
      prod_blue  <= 16'(pixel.blue_level) * 16'(brightness);
      prod_final <= pixel.final_pixel;
    end
  end

  assign push_valid            = prod_valid;
  assign push_data.grb         = {div255(prod_green), div255(prod_red), div255(prod_blue)};
  assign push_data.final_pixel = prod_final;

endmodule

// File: hw/rtl/alle_queue.sv
module alle_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  alle_pkg::scaled_t push_data,
  output logic              pop_valid,
  input  logic              pop,
  output alle_pkg::scaled_t pop_data
);
  import alle_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  scaled_t         entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = entries[rd_ptr];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/alle_back.sv
module alle_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  alle_pkg::scaled_t     q_data,
  input  alle_pkg::timing_cfg_t timing,
  output logic                  seg_valid,
  input  logic                  seg_ready,
  output alle_pkg::segment_t    seg
);
  import alle_pkg::*;

  logic               busy;
  logic [SegIdxW-1:0] idx;
  logic [23:0]        bits;
  logic               final_r;
  logic               adv;
  logic               last;
  logic               is_latch;
  logic               bit_one;
  segment_t           seg_next;

  assign adv      = busy && (!seg_valid || seg_ready);
  assign is_latch = (idx == SegIdxW'(LatchSeg));
  assign last     = final_r ? is_latch : (idx == SegIdxW'(SegsPerPixel - 1));
  // Load the next pixel as soon as the current one issues its last segment.
  assign q_pop    = q_valid && (!busy || (adv && last));
  assign bit_one  = bits[23];

  always_comb begin
    seg_next.run_end = last;
    if (is_latch) begin
      seg_next.line_level    = 1'b0;
      seg_next.segment_ticks = at_least_one(timing.latch_low_ticks);
    end else if (!idx[0]) begin
      seg_next.line_level    = 1'b1;
      seg_next.segment_ticks = at_least_one(16'(bit_one ? timing.one_high_ticks
                                                         : timing.zero_high_ticks));
    end else begin
      seg_next.line_level    = 1'b0;
      seg_next.segment_ticks = at_least_one(16'(bit_one ? timing.one_low_ticks
                                                         : timing.zero_low_ticks));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      seg_valid <= 1'b0;
    end else begin
      if (adv) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + SegIdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg <= seg_next;
    end
    if (q_pop) begin
      bits    <= q_data.grb;
      final_r <= q_data.final_pixel;
    end else if (adv && idx[0]) begin
      bits <= {bits[22:0], 1'b0};
    end
  end

endmodule

// File: hw/rtl/addressable_led_line_encoder.sv
// Serial encoder for a chain of addressable LEDs.
//
// Pixels arrive on the pixel channel (pixel_valid / pixel_ready), one
// transaction per pixel, carrying red, green and blue levels and a mark for
// the last pixel of a frame. Each level is scaled by the brightness register
// and the three bytes are sent green first, most significant bit first.
// Every bit leaves as two transactions on the seg channel: a high segment and
// a low segment, each with its length in clock ticks. A frame's last pixel
// adds one long low latch segment. run_end flags each pixel's last segment.
//
// The front end registers the products at the accepting edge and scales them
// as it writes the pixel into a two-entry queue; the back end then issues one
// segment per cycle from its output register while the receiver is ready and
// pixels are waiting. A pixel passes the product register, the queue, the
// sequencer's bit register and the output register in that order. The
// sequencer issues 48 segments per pixel, 49 for a frame's last.
// If the receiver stalls, the output register holds its segment and the
// queue fills, after which pixel_ready drops. Configuration writes
// (cfg_valid / cfg_ready) are always accepted and act at once. A synchronous
// reset empties the pipeline and restores the register defaults.
module addressable_led_line_encoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  alle_pkg::pixel_t                   pixel,
  output logic                               seg_valid,
  input  logic                               seg_ready,
  output alle_pkg::segment_t                 seg,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [alle_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [alle_pkg::CfgDataW-1:0]      cfg_data
);
  import alle_pkg::*;

  logic        [7:0] brightness;
  timing_cfg_t       timing;
  logic              push_valid;
  logic              push_ready;
  scaled_t           push_data;
  logic              q_valid;
  logic              q_pop;
  scaled_t           q_data;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness             <= BrightnessReset;
      timing.one_high_ticks  <= OneHighTicksReset;
      timing.one_low_ticks   <= OneLowTicksReset;
      timing.zero_high_ticks <= ZeroHighTicksReset;
      timing.zero_low_ticks  <= ZeroLowTicksReset;
      timing.latch_low_ticks <= LatchLowTicksReset;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to an index beyond the register list are dropped.
      unique case (cfg_index)
        REG_BRIGHTNESS:      brightness             <= cfg_data[7:0];
        REG_ONE_HIGH_TICKS:  timing.one_high_ticks  <= cfg_data[7:0];
        REG_ONE_LOW_TICKS:   timing.one_low_ticks   <= cfg_data[7:0];
        REG_ZERO_HIGH_TICKS: timing.zero_high_ticks <= cfg_data[7:0];
        REG_ZERO_LOW_TICKS:  timing.zero_low_ticks  <= cfg_data[7:0];
        REG_LATCH_LOW_TICKS: timing.latch_low_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: brightness scaling.
  alle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .brightness  (brightness),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // Decouples the scaler from the segment sequencer.
  alle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // Back end: one segment per cycle into the output register while the receiver is ready.
  alle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .timing    (timing),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

endmodule

// File: tb/addressable_led_line_encoder_tb.sv
module addressable_led_line_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alle_pkg::*;

  // Channel levels are scaled by brightness over this full-scale value.
  localparam logic [15:0] FullScale = 16'd255;
  // Register indexes beyond the list; writes to them must change nothing.
  localparam logic [CfgIndexW-1:0] SpareIndexLo = 3'd6;
  localparam logic [CfgIndexW-1:0] SpareIndexHi = 3'd7;
  // Only the first few mismatches are printed in full.
  localparam int MaxReports = 10;
  // Quiet cycles after the last expected segment, well past the pipeline latency.
  localparam int DrainCycles = 16;
  // Items per random phase and the length of the long receiver hold-off.
  localparam int PhaseItems = 110;
  localparam int HoldCycles = 600;

  // The scoreboard keeps its own copy of the registers and works out, for each
  // accepted pixel, the full run of line segments that the block should send.
  class led_line_scoreboard;
    segment_t    due_segments[$];
    logic [7:0]  brightness;
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [15:0] latch_low;
    int          faults;

    function new();
      brightness = 8'd255;
      one_high   = 8'd80;
      one_low    = 8'd40;
      zero_high  = 8'd32;
      zero_low   = 8'd72;
      latch_low  = 16'd8500;
      faults     = 0;
    endfunction

    function void note_config(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_BRIGHTNESS:      brightness = data[7:0];
        REG_ONE_HIGH_TICKS:  one_high   = data[7:0];
        REG_ONE_LOW_TICKS:   one_low    = data[7:0];
        REG_ZERO_HIGH_TICKS: zero_high  = data[7:0];
        REG_ZERO_LOW_TICKS:  zero_low   = data[7:0];
        REG_LATCH_LOW_TICKS: latch_low  = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] scaled(logic [7:0] lvl);
      return 8'((16'(lvl) * 16'(brightness)) / FullScale);
    endfunction

    function logic [15:0] min_one(logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function void add_pixel(pixel_t p);
      logic [23:0] grb;
      segment_t    s;
      logic        bit_one;
      grb = {scaled(p.green_level), scaled(p.red_level), scaled(p.blue_level)};
      for (int i = 23; i >= 0; i--) begin
        bit_one         = grb[i];
        s.line_level    = 1'b1;
        s.segment_ticks = min_one(16'(bit_one ? one_high : zero_high));
        s.run_end       = 1'b0;
        due_segments.push_back(s);
        s.line_level    = 1'b0;
        s.segment_ticks = min_one(16'(bit_one ? one_low : zero_low));
        s.run_end       = !p.final_pixel && (i == 0);
        due_segments.push_back(s);
      end
      if (p.final_pixel) begin
        s.line_level    = 1'b0;
        s.segment_ticks = min_one(latch_low);
        s.run_end       = 1'b1;
        due_segments.push_back(s);
      end
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      if (due_segments.size() == 0) begin
        faults++;
        if (faults <= MaxReports) begin
          $display("Unexpected segment: level %0b ticks %0d run_end %0b",
                   got.line_level, got.segment_ticks, got.run_end);
        end
        return;
      end
      want = due_segments.pop_front();
      if (got.line_level !== want.line_level || got.segment_ticks !== want.segment_ticks ||
          got.run_end !== want.run_end) begin
        faults++;
        if (faults <= MaxReports) begin
          $display("Segment mismatch: expected %0b/%0d/%0b, got %0b/%0d/%0b",
                   want.line_level, want.segment_ticks, want.run_end,
                   got.line_level, got.segment_ticks, got.run_end);
        end
      end
    endfunction

    function int pending();
      return due_segments.size();
    endfunction

    function int failures();
      return faults + due_segments.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_ready;
  pixel_t               pixel = '0;
  logic                 seg_valid;
  logic                 seg_ready = 1'b0;
  segment_t             seg;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // Idling percentages for the current phase, and the hold-off flag that
  // keeps the receiver from taking segments for a long stretch.
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_active    = 1'b0;

  led_line_scoreboard sb;

  addressable_led_line_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .seg_valid   (seg_valid),
    .seg_ready   (seg_ready),
    .seg         (seg),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver takes segments at random according to the stall
  // percentage, and not at all while a hold-off is running.
  always @(posedge clk) begin
    if (hold_active) begin
      seg_ready <= 1'b0;
    end else begin
      seg_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every transaction is observed at the edge that completes it. Inputs only
  // change by nonblocking assignment, so the values seen here are the ones
  // that the block itself saw at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.note_config(cfg_index, cfg_data);
      end
      if (pixel_valid && pixel_ready) begin
        sb.add_pixel(pixel);
      end
      if (seg_valid && seg_ready) begin
        sb.check_segment(seg);
      end
    end
  end

  function automatic pixel_t pix(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic f);
    pixel_t p;
    p.red_level   = r;
    p.green_level = g;
    p.blue_level  = b;
    p.final_pixel = f;
    return p;
  endfunction

  // Offers one pixel and returns at the edge where its transaction completes.
  // Valid is left high so that the next pixel can follow back to back.
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes the whole register set; only called while the block is idle.
  task automatic load_settings(input logic [7:0] bri, input logic [7:0] ohi,
                               input logic [7:0] olo, input logic [7:0] zhi,
                               input logic [7:0] zlo, input logic [15:0] latch);
    write_reg(REG_BRIGHTNESS, 16'(bri));
    write_reg(REG_ONE_HIGH_TICKS, 16'(ohi));
    write_reg(REG_ONE_LOW_TICKS, 16'(olo));
    write_reg(REG_ZERO_HIGH_TICKS, 16'(zhi));
    write_reg(REG_ZERO_LOW_TICKS, 16'(zlo));
    write_reg(REG_LATCH_LOW_TICKS, latch);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering pixels and waits until every expected segment has come
  // out, then lets the pipeline settle before anything else is changed.
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic hold_receiver(input int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  // One random phase: a fresh random register set, then a stream of random
  // pixels grouped into frames of random length. The brightness is pushed
  // towards its extremes now and then.
  task automatic random_phase(input int idle_pct, input int stall_pct, input int hold);
    int         pick;
    logic [7:0] bri;
    pick           = $urandom_range(3);
    bri            = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    load_settings(bri, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)));
    fork
      begin
        if (hold > 0) hold_receiver(hold);
      end
      begin
        for (int n = 0; n < PhaseItems; n++) begin
          send_pixel(pix(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), $urandom_range(5) == 0));
        end
      end
    join
    drain();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels at the reset settings, with no idling on either side:
    // black, white, each channel alone to pin down the green, red, blue
    // order, and alternating bit patterns, with and without the frame mark.
    send_pixel(pix(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(pix(8'hFF, 8'h00, 8'h00, 1'b0));
    send_pixel(pix(8'h00, 8'hFF, 8'h00, 1'b0));
    send_pixel(pix(8'h00, 8'h00, 8'hFF, 1'b0));
    send_pixel(pix(8'hAA, 8'h55, 8'h0F, 1'b0));
    send_pixel(pix(8'h80, 8'h01, 8'h7F, 1'b1));
    send_pixel(pix(8'h01, 8'hFE, 8'hC3, 1'b1));
    drain();

    // Every length register at zero must still give one-tick segments.
    load_settings(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    send_pixel(pix(8'hFF, 8'h00, 8'hA5, 1'b0));
    send_pixel(pix(8'h5A, 8'hFF, 8'h00, 1'b1));
    drain();

    // Writes to indexes past the register list are dropped, so the zero
    // lengths above must still be in force afterwards.
    write_reg(SpareIndexLo, 16'hFFFF);
    write_reg(SpareIndexHi, 16'hFFFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_pixel(pix(8'h3C, 8'hC3, 8'h99, 1'b1));
    drain();

    // Brightness at zero blanks every channel; lengths at their maximum.
    load_settings(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 1'b1));
    drain();

    // Brightness of one leaves only a full-scale level with a single bit.
    load_settings(8'd1, 8'd1, 8'd255, 8'd255, 8'd1, 16'd1);
    send_pixel(pix(8'hFF, 8'hFE, 8'h80, 1'b0));
    send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 1'b1));
    drain();

    load_settings(8'd128, 8'd255, 8'd1, 8'd1, 8'd255, 16'hFFFF);
    send_pixel(pix(8'hFF, 8'h7F, 8'hC0, 1'b1));
    send_pixel(pix(8'h02, 8'hFD, 8'h81, 1'b0));
    drain();

    // Random phases. The first has no idling, but the receiver holds off for
    // a long stretch at its start, so the queue fills and pixel transactions
    // stall. The others idle the sender, stall the receiver, or both.
    random_phase(0, 0, HoldCycles);
    random_phase(87, 0, 0);
    random_phase(0, 87, 0);
    random_phase(22, 22, 0);

    if (sb.pending() != 0) begin
      $display("%0d expected segments never arrived", sb.pending());
    end
    if (sb.failures() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Generous limit, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
